### hw/rtl/nspn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nspn_pkg;

  localparam int KEY_SLOTS = 12;
  localparam int SLOT_W    = $clog2(KEY_SLOTS);
  localparam int WORD_W    = 64;
  localparam int CELLS     = 16;
  localparam int NIB_W     = 4;

  localparam logic [WORD_W-1:0] SBOX_RST   = 64'h8013_CFD9_A7E2_45B6;
  localparam logic [WORD_W-1:0] MATRIX_RST = 64'h2113_3211_1321_1132;
  localparam logic [3:0]        ROUNDS_RST = 4'd4;

  // Reduction term of x^4+x+1 once the x^4 bit has been dropped.
  localparam logic [NIB_W-1:0]  GF_POLY    = 4'h3;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_ENCRYPT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CFG_SBOX   = 2'd0,
    CFG_MATRIX = 2'd1,
    CFG_ROUNDS = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_KEY0,
    S_ROUND,
    S_DONE
  } state_t;

  function automatic logic [NIB_W-1:0] gf16_mul(input logic [NIB_W-1:0] a_in,
                                                input logic [NIB_W-1:0] b_in);
    logic [NIB_W-1:0] a;
    logic [NIB_W-1:0] p;
    a = a_in;
    p = '0;
    for (int k = 0; k < NIB_W; k++) begin
      if (b_in[k]) begin
        p = p ^ a;
      end
      a = a[NIB_W-1] ? ({a[NIB_W-2:0], 1'b0} ^ GF_POLY) : {a[NIB_W-2:0], 1'b0};
    end
    return p;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/nspn_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module nspn_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 12
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### hw/rtl/nspn_round.sv
`timescale 1ns / 1ps
`default_nettype none

module nspn_round (
  input  wire logic [nspn_pkg::WORD_W-1:0] state_in,
  input  wire logic [nspn_pkg::WORD_W-1:0] round_key,
  input  wire logic [nspn_pkg::WORD_W-1:0] sbox_table,
  input  wire logic [nspn_pkg::WORD_W-1:0] mix_matrix,
  input  wire logic                        last_round,
  output logic      [nspn_pkg::WORD_W-1:0] state_out
);

  import nspn_pkg::*;

  logic [NIB_W-1:0] sub   [CELLS];
  logic [NIB_W-1:0] sh    [CELLS];
  logic [NIB_W-1:0] mixed [CELLS];
  logic [WORD_W-1:0] packed_w;

  always_comb begin
    for (int i = 0; i < CELLS; i++) begin
      sub[i] = sbox_table[NIB_W*state_in[NIB_W*i +: NIB_W] +: NIB_W];
    end
    // Row t of column c takes row t of the column t places further along, wrapping.
    for (int c = 0; c < 4; c++) begin
      for (int t = 0; t < 4; t++) begin
        sh[4*c+t] = sub[4*((c+t)%4)+t];
      end
    end
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        mixed[4*c+i] = '0;
        for (int t = 0; t < 4; t++) begin
          mixed[4*c+i] = mixed[4*c+i]
                       ^ gf16_mul(mix_matrix[NIB_W*(4*i+t) +: NIB_W], sh[4*c+t]);
        end
      end
    end
    for (int i = 0; i < CELLS; i++) begin
      packed_w[NIB_W*i +: NIB_W] = last_round ? sh[i] : mixed[i];
    end
    state_out = packed_w ^ round_key;
  end

endmodule

`default_nettype wire

### hw/rtl/nibble_spn_block_encrypt.sv
`timescale 1ns / 1ps
`default_nettype none

// Key load: no result word. Encrypt with r rounds: the word is
// taken, round key 0 is added in the next cycle, one round a cycle follows
// through the shared round unit (one key store read per cycle), and the
// result is registered from S_DONE once the output is free, with in_ready
// rising at that same edge, so no new word is taken before it is registered.
// Reset restores the config registers and control state, not the key store.
module nibble_spn_block_encrypt (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_op,
  input  wire logic [3:0]                  in_key_slot,
  input  wire logic [nspn_pkg::WORD_W-1:0] in_block_word,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [nspn_pkg::WORD_W-1:0] out_cipher_word,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [nspn_pkg::WORD_W-1:0] cfg_data
);

  import nspn_pkg::*;

  state_t              state_r, state_nxt;
  logic [SLOT_W-1:0]   round_r, round_nxt;
  logic [SLOT_W-1:0]   rounds_r, rounds_nxt;
  logic [WORD_W-1:0]   data_r, data_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]   out_data_r, out_data_nxt;
  logic [WORD_W-1:0]   sbox_r, matrix_r;
  logic [3:0]          rcount_r;

  logic                in_fire, cfg_fire, out_free;
  logic                ram_we;
  logic [SLOT_W-1:0]   rd_addr;
  logic [WORD_W-1:0]   key_word;
  logic [WORD_W-1:0]   round_out;
  logic                last_round;
  logic [SLOT_W-1:0]   rounds_sat;

  assign in_ready        = (state_r == S_IDLE);
  assign in_fire         = in_valid && in_ready;
  assign cfg_ready       = 1'b1;
  assign cfg_fire        = cfg_valid && cfg_ready;
  assign out_valid       = out_valid_r;
  assign out_cipher_word = out_data_r;
  assign out_free        = !out_valid_r || out_ready;
  assign last_round      = (round_r == rounds_r);

  // A load to a slot past the store is dropped.
  assign ram_we = in_fire && (in_op == OP_LOAD) && (int'(in_key_slot) < KEY_SLOTS);

  always_comb begin
    if (int'(rcount_r) > KEY_SLOTS - 1) begin
      rounds_sat = SLOT_W'(KEY_SLOTS - 1);
    end else if (rcount_r == 4'd0) begin
      rounds_sat = SLOT_W'(1);
    end else begin
      rounds_sat = SLOT_W'(rcount_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sbox_r   <= SBOX_RST;
      matrix_r <= MATRIX_RST;
      rcount_r <= ROUNDS_RST;
    end else if (cfg_fire) begin
      case (cfg_index)
        CFG_SBOX:   sbox_r   <= cfg_data;
        CFG_MATRIX: matrix_r <= cfg_data;
        CFG_ROUNDS: rcount_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  nspn_ram #(
    .WIDTH(WORD_W),
    .DEPTH(KEY_SLOTS)
  ) u_keys (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (in_key_slot[SLOT_W-1:0]),
    .wr_data (in_block_word),
    .rd_addr (rd_addr),
    .rd_data (key_word)
  );

  nspn_round u_round (
    .state_in   (data_r),
    .round_key  (key_word),
    .sbox_table (sbox_r),
    .mix_matrix (matrix_r),
    .last_round (last_round),
    .state_out  (round_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      round_r     <= '0;
      rounds_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      round_r     <= round_nxt;
      rounds_r    <= rounds_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r     <= data_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    round_nxt     = round_r;
    rounds_nxt    = rounds_r;
    data_nxt      = data_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    rd_addr       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire && (in_op == OP_ENCRYPT)) begin
          data_nxt   = in_block_word;
          rounds_nxt = rounds_sat;
          round_nxt  = SLOT_W'(1);
          state_nxt  = S_KEY0;
        end
      end
      S_KEY0: begin
        data_nxt  = data_r ^ key_word;
        rd_addr   = SLOT_W'(1);
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        data_nxt = round_out;
        // Fetch the next round's key; in the last round there is none to fetch.
        rd_addr  = last_round ? round_r : round_r + SLOT_W'(1);
        if (last_round) begin
          state_nxt = S_DONE;
        end else begin
          round_nxt = round_r + SLOT_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_data_nxt  = data_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_enc_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_op == OP_ENCRYPT)) |=> (state_r == S_KEY0))
    else $error("encrypt word accepted but key addition did not start");

  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND) |-> ((round_r != '0) && (round_r <= rounds_r)))
    else $error("round counter outside the configured round range");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_op == OP_LOAD) && !out_valid_r) |=> !out_valid_r)
    else $error("key load produced a result word");

  a_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_IDLE))
    else $error("key store written while an encrypt is running");

endmodule

`default_nettype wire

### verif/nibble_spn_block_encrypt_test.sv
`timescale 1ns / 1ps

module nibble_spn_block_encrypt_test;

  import nspn_pkg::*;

  localparam int PERIOD_NS    = 10;
  localparam int SETTLE_CYC   = 24;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 3000;
  localparam int PHASES       = 18;
  localparam int PHASE_ITEMS  = 100;
  localparam int BURST_ITEMS  = 60;

  // Register index with nothing behind it.
  localparam logic [1:0] CFG_UNMAPPED = 2'd3;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_op;
  logic [3:0]          in_key_slot;
  logic [WORD_W-1:0]   in_block_word;
  logic                out_valid;
  logic                out_ready;
  logic [WORD_W-1:0]   out_cipher_word;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [1:0]          cfg_index;
  logic [WORD_W-1:0]   cfg_data;

  nibble_spn_block_encrypt DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_key_slot     (in_key_slot),
    .in_block_word   (in_block_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_cipher_word (out_cipher_word),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // Shadow copy of the configuration and the key store.
  logic [WORD_W-1:0] sbox_reg;
  logic [WORD_W-1:0] matrix_reg;
  logic [3:0]        rounds_reg;
  logic [WORD_W-1:0] key_bank [KEY_SLOTS];

  logic [WORD_W-1:0] cipher_expect_q [$];
  int                fail_count;
  bit                no_idle;
  bit                hold_request;

  initial begin
    clk = 1'b0;
    forever #(PERIOD_NS / 2) clk = ~clk;
  end

  function automatic logic [3:0] gf16_times(logic [3:0] x, logic [3:0] y);
    logic [3:0] acc;
    acc = 4'h0;
    for (int k = 0; k < 4; k++) begin
      if (y[k]) begin
        acc = acc ^ x;
      end
      x = {x[2:0], 1'b0} ^ (x[3] ? 4'h3 : 4'h0);
    end
    return acc;
  endfunction

  function automatic logic [WORD_W-1:0] spn_round(logic [WORD_W-1:0] st,
                                                  logic [WORD_W-1:0] rk, bit last);
    logic [3:0]        sub [16];
    logic [3:0]        sh  [16];
    logic [3:0]        col [4];
    logic [3:0]        acc;
    logic [WORD_W-1:0] res;
    int                idx;
    for (int i = 0; i < 16; i++) begin
      idx = st[4*i +: 4];
      sub[i] = sbox_reg[4*idx +: 4];
    end
    // Row t of column c comes from column c+t.
    for (int c = 0; c < 4; c++) begin
      for (int t = 0; t < 4; t++) begin
        sh[4*c+t] = sub[4*((c+t)%4)+t];
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        for (int i = 0; i < 4; i++) begin
          acc = 4'h0;
          for (int t = 0; t < 4; t++) begin
            acc = acc ^ gf16_times(matrix_reg[4*(4*i+t) +: 4], sh[4*c+t]);
          end
          col[i] = acc;
        end
        for (int i = 0; i < 4; i++) begin
          sh[4*c+i] = col[i];
        end
      end
    end
    res = '0;
    for (int i = 0; i < 16; i++) begin
      res[4*i +: 4] = sh[i];
    end
    return res ^ rk;
  endfunction

  function automatic logic [WORD_W-1:0] encrypt_block(logic [WORD_W-1:0] plain);
    logic [WORD_W-1:0] st;
    int                nrounds;
    nrounds = rounds_reg;
    if (nrounds < 1) begin
      nrounds = 1;
    end
    if (nrounds > KEY_SLOTS - 1) begin
      nrounds = KEY_SLOTS - 1;
    end
    st = plain ^ key_bank[0];
    for (int i = 1; i < nrounds; i++) begin
      st = spn_round(st, key_bank[i], 1'b0);
    end
    return spn_round(st, key_bank[nrounds], 1'b1);
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] want,
                                 input logic [WORD_W-1:0] got);
    $display("%0t mismatch: %s expected %h got %h", $realtime, what, want, got);
    fail_count++;
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Offers one word and updates the shadow state when it is taken. The valid
  // is left high so that a following word can go back to back.
  task automatic send_word(input op_t op, input logic [3:0] slot,
                           input logic [WORD_W-1:0] word);
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < 36) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_key_slot   <= slot;
    in_block_word <= word;
    do begin
      @(posedge clk);
    end while (!in_ready);
    if (op == OP_ENCRYPT) begin
      cipher_expect_q.push_back(encrypt_block(word));
    end else if (slot < KEY_SLOTS) begin
      key_bank[slot] = word;
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [WORD_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    case (idx)
      CFG_SBOX:   sbox_reg   = data;
      CFG_MATRIX: matrix_reg = data;
      CFG_ROUNDS: rounds_reg = data[3:0];
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits for every expected word, then long enough for a trailing key load.
  task automatic drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (cipher_expect_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic test_key_store();
    send_word(OP_LOAD, 4'd0, '0);
    send_word(OP_LOAD, 4'd1, '1);
    for (int s = 2; s < KEY_SLOTS; s++) begin
      send_word(OP_LOAD, 4'(s), rand_word());
    end
    // Loads beyond the last slot must leave the store untouched.
    for (int s = KEY_SLOTS; s < 16; s++) begin
      send_word(OP_LOAD, 4'(s), rand_word());
    end
  endtask

  task automatic test_reset_config();
    send_word(OP_ENCRYPT, 4'hf, '0);
    send_word(OP_ENCRYPT, 4'h0, '1);
    send_word(OP_ENCRYPT, 4'h5, 64'h0123_4567_89AB_CDEF);
    send_word(OP_ENCRYPT, 4'ha, 64'hAAAA_5555_AAAA_5555);
    send_word(OP_ENCRYPT, 4'h3, 64'h8000_0000_0000_0001);
    drain_pipeline();
  endtask

  task automatic set_phase_config(input int p);
    logic [3:0] rc;
    case (p % 6)
      0: rc = 4'd0;
      1: rc = 4'd1;
      2: rc = 4'd11;
      3: rc = 4'd15;
      4: rc = 4'd4;
      default: rc = 4'($urandom_range(0, 15));
    endcase
    write_reg(CFG_ROUNDS, {60'(rand_word() >> 4), rc});
    case (p % 5)
      1: write_reg(CFG_SBOX, '0);
      2: write_reg(CFG_SBOX, '1);
      3: write_reg(CFG_SBOX, SBOX_RST);
      default: write_reg(CFG_SBOX, rand_word());
    endcase
    case (p % 4)
      1: write_reg(CFG_MATRIX, '0);
      2: write_reg(CFG_MATRIX, '1);
      3: write_reg(CFG_MATRIX, MATRIX_RST);
      default: write_reg(CFG_MATRIX, rand_word());
    endcase
    // Index three is unmapped and has to be ignored.
    if (p % 3 == 0) begin
      write_reg(CFG_UNMAPPED, rand_word());
    end
  endtask

  task automatic send_random_item();
    logic [WORD_W-1:0] w;
    int                pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      w = '0;
    end else if (pick < 10) begin
      w = '1;
    end else begin
      w = rand_word();
    end
    if ($urandom_range(0, 99) < 75) begin
      send_word(OP_ENCRYPT, 4'($urandom_range(0, 15)), w);
    end else begin
      send_word(OP_LOAD, 4'($urandom_range(0, 15)), w);
    end
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < PHASES; p++) begin
      set_phase_config(p);
      no_idle = (p == 7);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_random_item();
      end
      drain_pipeline();
      no_idle = 1'b0;
    end
  endtask

  task automatic test_output_backpressure();
    write_reg(CFG_ROUNDS, 64'd11);
    @(posedge clk);
    hold_request = 1'b1;
    for (int n = 0; n < BURST_ITEMS; n++) begin
      send_word(OP_ENCRYPT, 4'($urandom_range(0, 15)), rand_word());
    end
    drain_pipeline();
  endtask

  // Receiver: random ready, with one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= no_idle || ($urandom_range(0, 99) >= 36);
    end
  end

  initial begin
    logic [WORD_W-1:0] want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (cipher_expect_q.size() == 0) begin
          report_mismatch("word with none expected", '0, out_cipher_word);
        end else begin
          want = cipher_expect_q.pop_front();
          if (out_cipher_word !== want) begin
            report_mismatch("cipher_word", want, out_cipher_word);
          end
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("%0t stalled with %0d words outstanding", $realtime,
                 cipher_expect_q.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_op         = OP_LOAD;
    in_key_slot   = 4'h0;
    in_block_word = '0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_SBOX;
    cfg_data      = '0;
    fail_count    = 0;
    no_idle       = 1'b0;
    hold_request  = 1'b0;
    sbox_reg      = SBOX_RST;
    matrix_reg    = MATRIX_RST;
    rounds_reg    = ROUNDS_RST;
    for (int s = 0; s < KEY_SLOTS; s++) begin
      key_bank[s] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_key_store();
    test_reset_config();
    test_random_traffic();
    test_output_backpressure();

    drain_pipeline();
    if (cipher_expect_q.size() != 0) begin
      report_mismatch("words never delivered", '0, '0);
    end
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### nibble_spn_block_encrypt.f
hw/rtl/nspn_pkg.sv
hw/rtl/nspn_ram.sv
hw/rtl/nspn_round.sv
hw/rtl/nibble_spn_block_encrypt.sv
verif/nibble_spn_block_encrypt_test.sv
